### rtl/core/sacp_pkg.sv
// ----------------------------------------------------------------------------
// sacp_pkg
// Shared types and constants of the set-associative cache with prefetch.
// ----------------------------------------------------------------------------
package sacp_pkg;

	localparam int SETS      = 256;
	localparam int WAYS      = 8;
	localparam int ADDR_BITS = 48;
	localparam int SET_W     = 8;
	localparam int WAY_W     = 3;
	localparam int AGE_W     = 3;
	localparam int CNT_W     = 32;
	localparam logic [4:0] MAX_OFFSET   = 5'd16;
	localparam logic [3:0] MAX_INDEX    = 4'd8;
	localparam logic [3:0] MAX_WAYS     = 4'd8;
	localparam logic [3:0] MAX_PREFETCH = 4'd8;

	typedef enum logic [2:0] {
		REG_OFFSET   = 3'd0,
		REG_INDEX    = 3'd1,
		REG_WAYS     = 3'd2,
		REG_LRU      = 3'd3,
		REG_PREFETCH = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic                 mode;
		logic [ADDR_BITS-1:0] address;
	} req_t;

	typedef struct packed {
		logic             hit;
		logic [3:0]       mem_reads;
		logic             mem_write;
		logic [CNT_W-1:0] total_hits;
		logic [CNT_W-1:0] total_misses;
		logic [CNT_W-1:0] total_reads;
		logic [CNT_W-1:0] total_writes;
	} res_t;

	typedef struct packed {
		logic [WAY_W-1:0]                head;
		logic [WAYS-1:0]                 valid;
		logic [WAYS-1:0][AGE_W-1:0]      age;
		logic [WAYS-1:0][ADDR_BITS-1:0]  tag;
	} row_t;

	typedef struct packed {
		logic [3:0] ways;
		logic       lru;
	} pol_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [3:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W+1)'(b);
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

endpackage

### rtl/core/set_assoc_cache_with_prefetch.sv
// An accepted request reads its set, writes the updated row back and posts the result;
// on a miss each prefetched block, up to 8, repeats the set read and write back.
// One request at a time: the next request is taken only after the result is posted,
// and a result held by the receiver stalls the next request.
// After reset a clearing pass zeroes all 256 sets before the first request
// is taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// set_assoc_cache_with_prefetch
// Tag-only set-associative cache, FIFO or LRU, with next-line prefetch.
// ----------------------------------------------------------------------------
module set_assoc_cache_with_prefetch (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [4:0]          cfg_wdata,
	input  logic                req_valid,
	output logic                req_ready,
	input  sacp_pkg::req_t      req,
	output logic                res_valid,
	input  logic                res_ready,
	output sacp_pkg::res_t      res
);

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_RD   = 5'b00100,
		ST_WR   = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q;
	logic [4:0] offset_q;
	logic [3:0] index_q, ways_q, pf_q;
	logic       lru_q;
	logic [sacp_pkg::SET_W-1:0] clr_q;
	logic [sacp_pkg::ADDR_BITS-1:0] addr_q;
	logic       mode_q, first_q, hit_q;
	logic [3:0] cnt_q, reads_q;
	logic [sacp_pkg::CNT_W-1:0] hits_q, misses_q, mreads_q, mwrites_q;
	logic [sacp_pkg::CNT_W-1:0] hits_d, misses_d, mreads_d, mwrites_d;

	logic [4:0] eff_off;
	logic [3:0] eff_idx, eff_pf;
	sacp_pkg::pol_t pol;
	logic [sacp_pkg::ADDR_BITS-1:0] shifted, tag, bsize;
	logic [sacp_pkg::SET_W-1:0] set;
	logic       hit, go_on, res_free;

	sacp_pkg::row_t mem [sacp_pkg::SETS];
	sacp_pkg::row_t rd_row_s2, nxt_row;

	always_comb begin
		eff_off  = (offset_q > sacp_pkg::MAX_OFFSET) ? sacp_pkg::MAX_OFFSET : offset_q;
		eff_idx  = (index_q > sacp_pkg::MAX_INDEX) ? sacp_pkg::MAX_INDEX : index_q;
		eff_pf   = (pf_q > sacp_pkg::MAX_PREFETCH) ? sacp_pkg::MAX_PREFETCH : pf_q;
		pol.ways = (ways_q == 4'd0) ? 4'd1
			: ((ways_q > sacp_pkg::MAX_WAYS) ? sacp_pkg::MAX_WAYS : ways_q);
		pol.lru  = lru_q;
		shifted  = addr_q >> eff_off;
		set      = shifted[sacp_pkg::SET_W-1:0] & ~(8'hFF << eff_idx);
		tag      = addr_q >> (6'(eff_off) + 6'(eff_idx));
		bsize    = sacp_pkg::ADDR_BITS'(1) << eff_off;
		go_on    = !(first_q && hit) && (cnt_q < eff_pf);
		res_free = !res_valid || res_ready;
		hits_d    = sacp_pkg::sat_add(hits_q, {3'd0, hit_q});
		misses_d  = sacp_pkg::sat_add(misses_q, {3'd0, !hit_q});
		mreads_d  = sacp_pkg::sat_add(mreads_q, reads_q);
		mwrites_d = sacp_pkg::sat_add(mwrites_q, {3'd0, mode_q});
	end

	assign req_ready = (state_q == ST_IDLE);

	sacp_set_update u_upd (
		.cur       (rd_row_s2),
		.tag       (tag),
		.pol       (pol),
		.touch_hit (first_q),
		.hit       (hit),
		.nxt       (nxt_row)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR)
			mem[clr_q] <= '0;
		else if (state_q == ST_WR)
			mem[set] <= nxt_row;
		if (state_q == ST_RD)
			rd_row_s2 <= mem[set];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= 5'd6;
			index_q  <= '0;
			ways_q   <= 4'd1;
			lru_q    <= 1'b0;
			pf_q     <= '0;
		end else if (cfg_we) begin
			unique case (sacp_pkg::reg_idx_t'(cfg_index))
				sacp_pkg::REG_OFFSET:   offset_q <= cfg_wdata;
				sacp_pkg::REG_INDEX:    index_q  <= cfg_wdata[3:0];
				sacp_pkg::REG_WAYS:     ways_q   <= cfg_wdata[3:0];
				sacp_pkg::REG_LRU:      lru_q    <= cfg_wdata[0];
				sacp_pkg::REG_PREFETCH: pf_q     <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			first_q   <= 1'b0;
			hit_q     <= 1'b0;
			cnt_q     <= '0;
			reads_q   <= '0;
			res_valid <= 1'b0;
			hits_q    <= '0;
			misses_q  <= '0;
			mreads_q  <= '0;
			mwrites_q <= '0;
		end else begin
			if (state_q == ST_FIN && res_free)
				res_valid <= 1'b1;
			else if (res_valid && res_ready)
				res_valid <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 8'd1;
					if (clr_q == 8'hFF)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (req_valid) begin
						first_q <= 1'b1;
						cnt_q   <= '0;
						reads_q <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					if (first_q)
						hit_q <= hit;
					if (!hit)
						reads_q <= reads_q + 4'd1;
					if (go_on) begin
						cnt_q   <= cnt_q + 4'd1;
						first_q <= 1'b0;
						state_q <= ST_RD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_free) begin
						hits_q    <= hits_d;
						misses_q  <= misses_d;
						mreads_q  <= mreads_d;
						mwrites_q <= mwrites_d;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			addr_q <= req.address;
			mode_q <= req.mode;
		end else if (state_q == ST_WR && go_on) begin
			addr_q <= addr_q + bsize;
		end
		if (state_q == ST_FIN && res_free) begin
			res.hit          <= hit_q;
			res.mem_reads    <= reads_q;
			res.mem_write    <= mode_q;
			res.total_hits   <= hits_d;
			res.total_misses <= misses_d;
			res.total_reads  <= mreads_d;
			res.total_writes <= mwrites_d;
		end
	end

`ifndef SYNTH
	a_reads_vs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.hit ? (res.mem_reads == 4'd0) : (res.mem_reads != 4'd0)))
		else $error("mem_reads disagrees with hit");
	a_rise_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == ST_FIN)
		else $error("result posted outside finish");
	a_hit_no_prefetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR && first_q && hit) |=> state_q == ST_FIN)
		else $error("prefetch after demand hit");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> cnt_q <= sacp_pkg::MAX_PREFETCH)
		else $error("prefetch count overrun");
`endif

endmodule

### rtl/core/sacp_set_update.sv
// ----------------------------------------------------------------------------
// sacp_set_update
// Lookup, victim choice and age update over one set row.
// ----------------------------------------------------------------------------
module sacp_set_update (
	input  sacp_pkg::row_t                   cur,
	input  logic [sacp_pkg::ADDR_BITS-1:0]   tag,
	input  sacp_pkg::pol_t                   pol,
	input  logic                             touch_hit,
	output logic                             hit,
	output sacp_pkg::row_t                   nxt
);

	logic [sacp_pkg::WAYS-1:0]  in_use, match, empty;
	logic [sacp_pkg::WAY_W-1:0] hit_way, empty_way, lru_way, fifo_way, head_nxt, sel;
	logic [sacp_pkg::AGE_W-1:0] old_age, top_age;
	logic                       f_hit, f_empty, do_touch;

	always_comb begin
		top_age = sacp_pkg::AGE_W'(pol.ways - 4'd1);
		for (int w = 0; w < sacp_pkg::WAYS; w++) begin
			in_use[w] = 4'(w) < pol.ways;
			match[w]  = in_use[w] && cur.valid[w] && (cur.tag[w] == tag);
			empty[w]  = in_use[w] && !cur.valid[w];
		end
		hit_way = '0; empty_way = '0; f_hit = 1'b0; f_empty = 1'b0;
		for (int w = 0; w < sacp_pkg::WAYS; w++) begin
			if (match[w] && !f_hit) begin
				hit_way = sacp_pkg::WAY_W'(w);
				f_hit = 1'b1;
			end
			if (empty[w] && !f_empty) begin
				empty_way = sacp_pkg::WAY_W'(w);
				f_empty = 1'b1;
			end
		end
		lru_way = '0;
		for (int w = 1; w < sacp_pkg::WAYS; w++) begin
			if (in_use[w] && cur.age[w] < cur.age[lru_way])
				lru_way = sacp_pkg::WAY_W'(w);
		end
		fifo_way = ({1'b0, cur.head} < pol.ways) ? cur.head : '0;
		head_nxt = ((4'(fifo_way) + 4'd1) >= pol.ways) ? '0 : fifo_way + 3'd1;

		nxt = cur;
		hit = |match;
		if (hit) begin
			sel = hit_way;
			old_age = cur.age[hit_way];
			do_touch = pol.lru && touch_hit;
		end else begin
			if (f_empty) begin
				sel = empty_way;
				old_age = '0;
			end else if (pol.lru) begin
				sel = lru_way;
				old_age = cur.age[lru_way];
			end else begin
				sel = fifo_way;
				old_age = '0;
				nxt.head = head_nxt;
			end
			do_touch = pol.lru;
			nxt.tag[sel] = tag;
			nxt.valid[sel] = 1'b1;
			if (!pol.lru)
				nxt.age[sel] = '0;
		end
		if (do_touch) begin
			for (int j = 0; j < sacp_pkg::WAYS; j++) begin
				if (in_use[j] && sacp_pkg::WAY_W'(j) != sel && cur.valid[j]
						&& cur.age[j] > old_age)
					nxt.age[j] = cur.age[j] - 3'd1;
			end
			nxt.age[sel] = top_age;
		end
	end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the set-associative cache with prefetch. It runs directed
// corner requests, then random request streams under a series of cache
// settings. A predictor tracks every set, way and counter, and each result
// is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [4:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	sacp_pkg::req_t req = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	sacp_pkg::res_t res;

	set_assoc_cache_with_prefetch i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .req_valid(req_valid), .req_ready(req_ready),
		.req(req), .res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// cache image
	logic [sacp_pkg::ADDR_BITS-1:0] m_tag [sacp_pkg::SETS*sacp_pkg::WAYS];
	bit m_valid [sacp_pkg::SETS*sacp_pkg::WAYS];
	int unsigned m_age [sacp_pkg::SETS*sacp_pkg::WAYS];
	int unsigned m_head [sacp_pkg::SETS];
	logic [sacp_pkg::CNT_W-1:0] n_hits, n_misses, n_reads, n_writes;
	logic [4:0] c_offset = 5'd6;
	logic [3:0] c_index = 4'd0, c_ways = 4'd1, c_prefetch = 4'd0;
	logic c_lru = 1'b0;

	sacp_pkg::req_t pending_reqs [$];
	sacp_pkg::res_t expected_res [$];
	bit failed = 0;
	bit idling = 1;
	int unsigned sent = 0, checked = 0, hit_seen = 0, cycles = 0;
	int unsigned req_gap = 0, res_gap = 0, long_hold = 0;
	bit long_done = 0;
	logic [sacp_pkg::ADDR_BITS-1:0] pool [8];

	function automatic int unsigned eff_off();
		return c_offset > 16 ? 16 : 32'(c_offset);
	endfunction
	function automatic int unsigned eff_idx();
		return c_index > 8 ? 8 : 32'(c_index);
	endfunction
	function automatic int unsigned eff_ways();
		if (c_ways == 0) return 1;
		return c_ways > 8 ? 8 : 32'(c_ways);
	endfunction

	function automatic void make_recent(int unsigned base, int unsigned w,
			int unsigned old_age, int unsigned n);
		for (int unsigned j = 0; j < n; j++)
			if (j != w && m_valid[base+j] && m_age[base+j] > old_age)
				m_age[base+j]--;
		m_age[base+w] = n - 1;
	endfunction

	function automatic bit lookup_block(logic [sacp_pkg::ADDR_BITS-1:0] a, bit touch_hit);
		int unsigned ob, ib, n, base, victim, old_age, s;
		logic [63:0] tg;
		ob = eff_off();
		ib = eff_idx();
		n = eff_ways();
		s = int'((64'(a) >> ob) & ((64'd1 << ib) - 1));
		tg = 64'(a) >> (ob + ib);
		base = s * sacp_pkg::WAYS;
		victim = n;
		old_age = 0;
		for (int unsigned w = 0; w < n; w++)
			if (m_valid[base+w] && 64'(m_tag[base+w]) == tg) begin
				if (c_lru && touch_hit) make_recent(base, w, m_age[base+w], n);
				return 1;
			end
		for (int unsigned w = 0; w < n; w++)
			if (!m_valid[base+w]) begin
				victim = w;
				break;
			end
		if (victim == n) begin
			if (c_lru) begin
				victim = 0;
				for (int unsigned w = 1; w < n; w++)
					if (m_age[base+w] < m_age[base+victim]) victim = w;
				old_age = m_age[base+victim];
			end else begin
				victim = m_head[s] < n ? m_head[s] : 0;
				m_head[s] = victim + 1 >= n ? 0 : victim + 1;
			end
		end
		m_tag[base+victim] = tg[sacp_pkg::ADDR_BITS-1:0];
		m_valid[base+victim] = 1;
		if (c_lru) make_recent(base, victim, old_age, n);
		else m_age[base+victim] = 0;
		return 0;
	endfunction

	function automatic logic [sacp_pkg::CNT_W-1:0] bump(logic [sacp_pkg::CNT_W-1:0] a,
			int unsigned b);
		logic [sacp_pkg::CNT_W:0] s;
		s = {1'b0, a} + (sacp_pkg::CNT_W+1)'(b);
		return s[sacp_pkg::CNT_W] ? '1 : s[sacp_pkg::CNT_W-1:0];
	endfunction

	function automatic void predict_access(sacp_pkg::req_t r);
		sacp_pkg::res_t e;
		logic [sacp_pkg::ADDR_BITS-1:0] a;
		int unsigned reads, depth;
		bit h;
		a = r.address;
		reads = 0;
		h = lookup_block(a, 1);
		if (h) n_hits = bump(n_hits, 1);
		else begin
			n_misses = bump(n_misses, 1);
			reads = 1;
			depth = c_prefetch > 8 ? 8 : 32'(c_prefetch);
			for (int unsigned k = 0; k < depth; k++) begin
				a = a + (sacp_pkg::ADDR_BITS'(1) << eff_off());
				if (!lookup_block(a, 0)) reads++;
			end
		end
		n_reads = bump(n_reads, reads);
		if (r.mode) n_writes = bump(n_writes, 1);
		e.hit = h;
		e.mem_reads = 4'(reads);
		e.mem_write = r.mode;
		e.total_hits = n_hits;
		e.total_misses = n_misses;
		e.total_reads = n_reads;
		e.total_writes = n_writes;
		expected_res.push_back(e);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				predict_access(req);
				sent++;
			end
			if (!(req_valid && !req_ready)) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
					if (idling && $urandom_range(0, 7) == 0) req_gap = $urandom_range(1, 6);
				end else
					req_valid <= 1'b0;
			end
		end
	end

	task automatic chk(string name, logic [sacp_pkg::CNT_W-1:0] e,
			logic [sacp_pkg::CNT_W-1:0] a);
		if (e !== a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			failed = 1;
		end
	endtask

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_res.size() == 0) begin
					$error("result with no request outstanding");
					failed = 1;
				end else begin
					sacp_pkg::res_t e;
					e = expected_res.pop_front();
					chk("hit", sacp_pkg::CNT_W'(e.hit), sacp_pkg::CNT_W'(res.hit));
					chk("mem_reads", sacp_pkg::CNT_W'(e.mem_reads),
						sacp_pkg::CNT_W'(res.mem_reads));
					chk("mem_write", sacp_pkg::CNT_W'(e.mem_write),
						sacp_pkg::CNT_W'(res.mem_write));
					chk("total_hits", e.total_hits, res.total_hits);
					chk("total_misses", e.total_misses, res.total_misses);
					chk("total_reads", e.total_reads, res.total_reads);
					chk("total_writes", e.total_writes, res.total_writes);
					checked++;
					if (e.hit) hit_seen++;
				end
			end
			if (!long_done && sent >= 300) begin
				long_done = 1;
				long_hold = 300;
			end
			if (long_hold > 0) begin
				long_hold--;
				res_ready <= 1'b0;
			end else if (res_gap > 0) begin
				res_gap--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				if (idling && $urandom_range(0, 7) == 0) res_gap = $urandom_range(1, 6);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(sacp_pkg::reg_idx_t i, logic [4:0] v);
		cfg_we <= 1'b1;
		cfg_index <= i;
		cfg_wdata <= v;
		case (i)
			sacp_pkg::REG_OFFSET: c_offset = v;
			sacp_pkg::REG_INDEX: c_index = v[3:0];
			sacp_pkg::REG_WAYS: c_ways = v[3:0];
			sacp_pkg::REG_LRU: c_lru = v[0];
			default: c_prefetch = v[3:0];
		endcase
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic setup(logic [4:0] o, logic [3:0] ix, logic [3:0] w, logic l,
			logic [3:0] p);
		drain();
		write_reg(sacp_pkg::REG_OFFSET, o);
		write_reg(sacp_pkg::REG_INDEX, {1'b0, ix});
		write_reg(sacp_pkg::REG_WAYS, {1'b0, w});
		write_reg(sacp_pkg::REG_LRU, {4'b0, l});
		write_reg(sacp_pkg::REG_PREFETCH, {1'b0, p});
		cfg_we <= 1'b0;
		for (int i = 0; i < 8; i++) pool[i] = sacp_pkg::ADDR_BITS'({$urandom, $urandom});
	endtask

	function automatic void add_req(logic m, logic [sacp_pkg::ADDR_BITS-1:0] a);
		sacp_pkg::req_t r;
		r.mode = m;
		r.address = a;
		pending_reqs.push_back(r);
	endfunction

	function automatic logic [sacp_pkg::ADDR_BITS-1:0] pick_addr();
		int unsigned r, ob, ib;
		ob = eff_off();
		ib = eff_idx();
		r = $urandom_range(0, 9);
		if (r == 0) return sacp_pkg::ADDR_BITS'({$urandom, $urandom});
		if (r == 1) return '1 - sacp_pkg::ADDR_BITS'($urandom_range(0, 300));
		return pool[$urandom_range(0, 7)]
			+ (sacp_pkg::ADDR_BITS'($urandom_range(0, 11)) << (ob + ib))
			+ (sacp_pkg::ADDR_BITS'($urandom_range(0, 3)) << ob)
			+ sacp_pkg::ADDR_BITS'($urandom_range(0, 255));
	endfunction

	initial begin
		logic [4:0] cfgs [10][5] = '{
			'{5'd0, 5'd0, 5'd8, 5'd1, 5'd8}, '{5'd16, 5'd8, 5'd8, 5'd0, 5'd8},
			'{5'd31, 5'd15, 5'd15, 5'd1, 5'd15}, '{5'd4, 5'd2, 5'd4, 5'd1, 5'd3},
			'{5'd5, 5'd3, 5'd2, 5'd0, 5'd2}, '{5'd6, 5'd1, 5'd0, 5'd1, 5'd1},
			'{5'd3, 5'd8, 5'd8, 5'd1, 5'd0}, '{5'd2, 5'd0, 5'd8, 5'd0, 5'd4},
			'{5'd17, 5'd4, 5'd3, 5'd1, 5'd9}, '{5'd6, 5'd2, 5'd8, 5'd1, 5'd2}
		};
		for (int i = 0; i < sacp_pkg::SETS*sacp_pkg::WAYS; i++) m_valid[i] = 0;
		for (int i = 0; i < sacp_pkg::SETS; i++) m_head[i] = 0;
		n_hits = '0;
		n_misses = '0;
		n_reads = '0;
		n_writes = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: reset settings, deep prefetch across the address wrap, then two-way FIFO eviction
		add_req(1'b0, '0);
		add_req(1'b0, '0);
		add_req(1'b1, '1);
		add_req(1'b1, '1);
		add_req(1'b0, 48'h40);
		add_req(1'b1, 48'h0);
		add_req(1'b0, 48'hAAAA_AAAA_AAAA);
		add_req(1'b1, 48'h5555_5555_5555);
		setup(5'd6, 4'd0, 4'd8, 1'b1, 4'd8);
		add_req(1'b0, 48'hFFFF_FFFF_FFC0);
		add_req(1'b0, 48'h0000_0000_0100);
		add_req(1'b1, 48'h0000_0000_0000);
		add_req(1'b0, 48'h0000_0000_1000);
		add_req(1'b0, 48'h0000_0000_2000);
		add_req(1'b1, 48'hFFFF_FFFF_FFFF);
		setup(5'd6, 4'd1, 4'd2, 1'b0, 4'd0);
		for (int i = 0; i < 8; i++) add_req(i[0], 48'(i) << 7);
		add_req(1'b0, 48'h0);
		add_req(1'b0, 48'h80);
		for (int p = 0; p < 10; p++) begin
			setup(cfgs[p][0], cfgs[p][1][3:0], cfgs[p][2][3:0], cfgs[p][3][0],
				cfgs[p][4][3:0]);
			if (p == 9) idling = 0;
			for (int i = 0; i < 98; i++) add_req(1'($urandom_range(0, 1)), pick_addr());
		end
		drain();
		$display("%0d requests under 13 cache settings, %0d results checked, %0d hits",
			sent, checked, hit_seen);
		if (!failed) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
